// ===== design/integer_to_ascii_formatter_core_assert.svh =====
// ----------------------------------------------------------------------------
// integer to ascii formatter: assertion macros
// Shared property wrappers, clocked on clk; IAF_ASSERT is quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// implication checked on every rising edge outside of reset
`define IAF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// same wrapper, with the reset also covered by the check
`define IAF_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/iaf_pkg.sv =====
// ----------------------------------------------------------------------------
// iaf_pkg
// Types, codes and character helpers shared by the formatter modules.
// ----------------------------------------------------------------------------
package iaf_pkg;

	// format modes
	typedef enum logic [2:0] {
		MODE_SDEC = 3'd0,
		MODE_UDEC = 3'd1,
		MODE_HEXL = 3'd2,
		MODE_HEXU = 3'd3,
		MODE_PTR  = 3'd4
	} mode_t;

	localparam int VAL_W      = 64;
	localparam int BIN_W      = 32;
	localparam int CHAR_W     = 7;
	localparam int NIB_W      = 4;
	localparam int DIG_MAX    = VAL_W / NIB_W;
	localparam int DEC_DIGITS = 10;
	localparam int NIL_LEN    = 5;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_LOWA  = 7'h61;
	localparam logic [CHAR_W-1:0] CH_UPA   = 7'h41;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

	// one input item
	typedef struct packed {
		logic [2:0]       action;
		logic [VAL_W-1:0] value;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv;
		logic skip;
		logic emit_sign;
		logic emit_digit;
		logic emit_nil;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_nil;
		logic is_dec;
		logic negative;
		logic conv_done;
		logic lead_zero;
		logic digit_last;
		logic nil_last;
	} stat_t;

	// ascii of one hex or decimal digit
	function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] nib,
		input logic upper);
		logic [CHAR_W-1:0] base;
		begin
			base = upper ? CH_UPA : CH_LOWA;
			if (nib < 4'd10)
				digit_char = CH_ZERO + CHAR_W'(nib);
			else
				digit_char = base + CHAR_W'(nib - 4'd10);
		end
	endfunction

	// "(nil)" text by position
	function automatic logic [CHAR_W-1:0] nil_char(input logic [2:0] idx);
		logic [CHAR_W-1:0] c;
		begin
			case (idx)
				3'd0:    c = 7'h28;
				3'd1:    c = 7'h6e;
				3'd2:    c = 7'h69;
				3'd3:    c = 7'h6c;
				3'd4:    c = 7'h29;
				default: c = 7'h29;
			endcase
			nil_char = c;
		end
	endfunction

endpackage

// ===== design/iaf_datapath.sv =====
// ----------------------------------------------------------------------------
// iaf_datapath
// Digit register, binary to bcd shifter, leading zero skip and result register.
// ----------------------------------------------------------------------------
module iaf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  iaf_pkg::in_item_t item,
	input  iaf_pkg::cmd_t     cmd,
	output iaf_pkg::stat_t    stat,
	output logic              strobe,
	output iaf_pkg::out_item_t result
);

	logic [iaf_pkg::VAL_W-1:0] dig_q;
	logic [iaf_pkg::BIN_W-1:0] bin_q;
	logic [4:0]                cnt_q;
	logic [4:0]                ndig_q;
	logic                      neg_q;
	logic                      dec_q;
	logic                      upper_q;
	logic                      nil_q;
	logic                      strobe_q;
	iaf_pkg::out_item_t        res_q;

	logic [iaf_pkg::BIN_W-1:0] low;
	logic [iaf_pkg::VAL_W-1:0] adj;
	logic [iaf_pkg::NIB_W-1:0] top_nib;

	assign low     = item.value[iaf_pkg::BIN_W-1:0];
	assign top_nib = dig_q[iaf_pkg::VAL_W-1 -: iaf_pkg::NIB_W];

	// add three to every bcd digit of five or more before the shift
	always_comb begin
		adj = dig_q;
		for (int i = 0; i < iaf_pkg::DEC_DIGITS; i++) begin
			if (dig_q[i*iaf_pkg::NIB_W +: iaf_pkg::NIB_W] >= 4'd5)
				adj[i*iaf_pkg::NIB_W +: iaf_pkg::NIB_W] =
					dig_q[i*iaf_pkg::NIB_W +: iaf_pkg::NIB_W] + 4'd3;
		end
	end

	// digit register and counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q   <= '0;
			ndig_q  <= 5'(iaf_pkg::DIG_MAX);
			neg_q   <= 1'b0;
			dec_q   <= 1'b0;
			upper_q <= 1'b0;
			nil_q   <= 1'b0;
			bin_q   <= low;
			dig_q   <= {{(iaf_pkg::VAL_W-iaf_pkg::BIN_W){1'b0}}, low};
			case (item.action)
				iaf_pkg::MODE_SDEC: begin
					dec_q <= 1'b1;
					neg_q <= low[iaf_pkg::BIN_W-1];
					dig_q <= '0;
					if (low[iaf_pkg::BIN_W-1])
						bin_q <= ~low + 1'b1;
				end
				iaf_pkg::MODE_UDEC: begin
					dec_q <= 1'b1;
					dig_q <= '0;
				end
				iaf_pkg::MODE_HEXU: begin
					upper_q <= 1'b1;
				end
				iaf_pkg::MODE_PTR: begin
					dig_q <= item.value;
					nil_q <= (item.value == '0);
				end
				default: begin
				end
			endcase
		end else if (cmd.conv) begin
			dig_q <= {adj[iaf_pkg::VAL_W-2:0], bin_q[iaf_pkg::BIN_W-1]};
			bin_q <= {bin_q[iaf_pkg::BIN_W-2:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
		end else if (cmd.skip || cmd.emit_digit) begin
			dig_q  <= {dig_q[iaf_pkg::VAL_W-iaf_pkg::NIB_W-1:0], {iaf_pkg::NIB_W{1'b0}}};
			ndig_q <= ndig_q - 5'd1;
		end else if (cmd.emit_nil) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// status back to the controller
	always_comb begin
		stat.is_nil     = nil_q;
		stat.is_dec     = dec_q;
		stat.negative   = neg_q;
		stat.conv_done  = (cnt_q == 5'(iaf_pkg::BIN_W - 1));
		stat.lead_zero  = (top_nib == '0) && (ndig_q != 5'd1);
		stat.digit_last = (ndig_q == 5'd1);
		stat.nil_last   = (cnt_q[2:0] == 3'(iaf_pkg::NIL_LEN - 1));
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.emit_sign | cmd.emit_digit | cmd.emit_nil;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			res_q.char_code <= iaf_pkg::CH_MINUS;
			res_q.last      <= 1'b0;
		end else if (cmd.emit_nil) begin
			res_q.char_code <= iaf_pkg::nil_char(cnt_q[2:0]);
			res_q.last      <= stat.nil_last;
		end else if (cmd.emit_digit) begin
			res_q.char_code <= iaf_pkg::digit_char(top_nib, upper_q);
			res_q.last      <= stat.digit_last;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

// ===== design/iaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// iaf_ctrl
// Sequencer: load, bcd conversion, zero skip, sign and character emission.
// ----------------------------------------------------------------------------
module iaf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        action,
	input  iaf_pkg::stat_t    stat,
	output iaf_pkg::cmd_t     cmd,
	output logic              busy
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PREP  = 7'b0000010,
		ST_CONV  = 7'b0000100,
		ST_SKIP  = 7'b0001000,
		ST_SIGN  = 7'b0010000,
		ST_DIGIT = 7'b0100000,
		ST_NIL   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   mode_ok;

	assign mode_ok = action inside {[iaf_pkg::MODE_SDEC:iaf_pkg::MODE_PTR]};

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start && mode_ok) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				if (stat.is_nil)
					state_d = ST_NIL;
				else if (stat.is_dec)
					state_d = ST_CONV;
				else
					state_d = ST_SKIP;
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				if (stat.conv_done)
					state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (stat.lead_zero)
					cmd.skip = 1'b1;
				else if (stat.negative)
					state_d = ST_SIGN;
				else
					state_d = ST_DIGIT;
			end
			ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_d       = ST_DIGIT;
			end
			ST_DIGIT: begin
				cmd.emit_digit = 1'b1;
				if (stat.digit_last)
					state_d = ST_IDLE;
			end
			ST_NIL: begin
				cmd.emit_nil = 1'b1;
				if (stat.nil_last)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== design/integer_to_ascii_formatter_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a 32-bit or 64-bit integer as ascii, one character per result.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; the characters then
// come out most significant first, one per strobe cycle, the final one with
// last set, and must be taken as they appear. With n characters an item holds
// busy through: hex modes prep, 16 - n zero skips, the step that leaves the
// skip state and n digits; decimal modes the same with the 32 shift-and-adjust
// steps of the bcd converter added, and a sign step for a minus sign; zero
// pointer prep and five characters. An undefined mode is taken and gives no
// characters. The last strobe shows in the first cycle with busy low, so the
// next item may be taken while it is on the result ports.
module integer_to_ascii_formatter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  iaf_pkg::in_item_t  item,
	output logic               strobe,
	output iaf_pkg::out_item_t result
);

	iaf_pkg::cmd_t  cmd;
	iaf_pkg::stat_t stat;

	// sequencer
	iaf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// digit datapath
	iaf_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule

// ===== design/iaf_checker.sv =====
// ----------------------------------------------------------------------------
// iaf_checker
// Port level checks on the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_core_assert.svh"

module iaf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input iaf_pkg::in_item_t  item,
	input logic               strobe,
	input iaf_pkg::out_item_t result
);

	logic mode_ok;
	logic take_ok;
	logic take_bad;

	// accepted items split by defined and undefined mode
	assign mode_ok  = item.action inside {[iaf_pkg::MODE_SDEC:iaf_pkg::MODE_PTR]};
	assign take_ok  = start && !busy && mode_ok;
	assign take_bad = start && !busy && !mode_ok;

	// a valid item keeps the block busy in the next cycle
	`IAF_ASSERT(a_valid_busy, take_ok |=> busy, "valid item not taken")

	// an undefined mode leaves the block idle and silent
	`IAF_ASSERT(a_bad_idle, take_bad |=> !busy && !strobe, "undefined mode produced work")

	// a character seen while idle is the final one
	`IAF_ASSERT(a_idle_last, strobe && !busy |-> result.last, "idle character not marked last")

	// nothing follows the final character directly
	`IAF_ASSERT(a_last_gap, strobe && result.last |=> !strobe, "character right after last")

	// no strobe in the cycle after reset release
	`IAF_ASSERT_RST(a_rst_quiet, !arst_n |=> !strobe, "strobe out of reset")

endmodule

bind integer_to_ascii_formatter_core iaf_checker u_iaf_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: integer_to_ascii_formatter_core bench
// Sends format items in all five modes plus the undefined codes, predicts the
// character stream of each number and checks every strobed character in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int RANDOM_ITEMS = 335;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 60;

	localparam logic [7:0]  ASC_ZERO    = "0";
	localparam logic [7:0]  ASC_LOWER_A = "a";
	localparam logic [7:0]  ASC_UPPER_A = "A";
	localparam logic [7:0]  ASC_MINUS   = "-";
	localparam logic [39:0] NIL_TEXT    = "(nil)";

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	iaf_pkg::in_item_t  item;
	logic               strobe;
	iaf_pkg::out_item_t result;

	iaf_pkg::out_item_t expected_chars[$];
	int                 mismatches = 0;
	int                 chars_checked = 0;
	int                 mode_count[8];

	integer_to_ascii_formatter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void note_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch: %s", $realtime, what);
	endfunction

	// expected character stream of one item, pushed onto expected_chars
	task automatic predict_chars(input logic [2:0] act, input logic [63:0] val);
		logic [63:0]        mag;
		logic [31:0]        low;
		logic [4:0]         radix;
		logic               neg;
		logic               upper;
		logic [3:0]         dig;
		logic [7:0]         text[$];
		iaf_pkg::out_item_t ch;
		neg = 1'b0;
		upper = 1'b0;
		radix = 5'd16;
		mag = '0;
		case (act)
			iaf_pkg::MODE_SDEC: begin
				low = val[31:0];
				if (low[31]) begin
					neg = 1'b1;
					low = ~low + 32'd1;
				end
				mag = {32'd0, low};
				radix = 5'd10;
			end
			iaf_pkg::MODE_UDEC: begin
				mag = {32'd0, val[31:0]};
				radix = 5'd10;
			end
			iaf_pkg::MODE_HEXL: mag = {32'd0, val[31:0]};
			iaf_pkg::MODE_HEXU: begin
				mag = {32'd0, val[31:0]};
				upper = 1'b1;
			end
			iaf_pkg::MODE_PTR: begin
				mag = val;
				if (val == '0) begin
					for (int k = 0; k < 5; k++)
						text.push_back(NIL_TEXT[8*(4-k) +: 8]);
				end
			end
			default: return;
		endcase
		// digits least significant first, built up from back to front
		if (text.size() == 0) begin
			do begin
				dig = 4'(mag % radix);
				if (dig < 4'd10)
					text.push_front(ASC_ZERO + dig);
				else
					text.push_front((upper ? ASC_UPPER_A : ASC_LOWER_A) + dig - 8'd10);
				mag = mag / radix;
			end while (mag != '0);
			if (neg)
				text.push_front(ASC_MINUS);
		end
		foreach (text[k]) begin
			ch.char_code = text[k][6:0];
			ch.last = (k == text.size() - 1);
			expected_chars.push_back(ch);
		end
	endtask

	// present one item and hold it until the block takes it
	task automatic send_item(input logic [2:0] act, input logic [63:0] val);
		start <= 1'b1;
		item <= '{action: act, value: val};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_chars(act, val);
		mode_count[act]++;
	endtask

	// drop start for a while, with junk on the item bus
	task automatic idle_gap(input int cycles);
		start <= 1'b0;
		item <= '{action: 3'($urandom), value: {$urandom, $urandom}};
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_idle(input bit allowed);
		if (allowed && $urandom_range(0, 99) < 11)
			idle_gap($urandom_range(1, 60));
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = 64'($urandom_range(0, 20));
			2: v = 64'd1 << $urandom_range(0, 63);
			3: v = (64'd1 << $urandom_range(1, 63)) - 64'd1;
			4: v = {v[63:32], 32'h8000_0000 + 32'($urandom_range(0, 2)) - 32'd1};
			5: v = v >> $urandom_range(0, 60);
			default: ;
		endcase
		return v;
	endfunction

	// result checker: each strobe against the oldest expected character
	always @(posedge clk) begin
		iaf_pkg::out_item_t want;
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				note_mismatch($sformatf("unexpected char %h last %b",
					result.char_code, result.last));
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (result.char_code !== want.char_code || result.last !== want.last)
					note_mismatch($sformatf("char exp %h got %h, last exp %b got %b",
						want.char_code, result.char_code, want.last, result.last));
			end
		end
	end

	task automatic test_signed_decimal();
		send_item(iaf_pkg::MODE_SDEC, 64'd0);
		send_item(iaf_pkg::MODE_SDEC, 64'd7);
		send_item(iaf_pkg::MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(iaf_pkg::MODE_SDEC, 64'h0000_0000_7FFF_FFFF);
		send_item(iaf_pkg::MODE_SDEC, 64'h0000_0000_8000_0000);
		send_item(iaf_pkg::MODE_SDEC, 64'hA5A5_A5A5_0000_3039);
	endtask

	task automatic test_unsigned_decimal();
		send_item(iaf_pkg::MODE_UDEC, 64'hFFFF_FFFF_0000_0000);
		send_item(iaf_pkg::MODE_UDEC, 64'h0000_0000_FFFF_FFFF);
		send_item(iaf_pkg::MODE_UDEC, 64'd1000000000);
		send_item(iaf_pkg::MODE_UDEC, 64'h0000_0000_8000_0000);
	endtask

	task automatic test_hex_cases();
		send_item(iaf_pkg::MODE_HEXL, 64'd0);
		send_item(iaf_pkg::MODE_HEXL, 64'h1234_5678_DEAD_BEEF);
		send_item(iaf_pkg::MODE_HEXU, 64'h0000_0000_DEAD_BEEF);
		send_item(iaf_pkg::MODE_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(iaf_pkg::MODE_HEXL, 64'h0000_0000_0000_000A);
	endtask

	task automatic test_pointer();
		send_item(iaf_pkg::MODE_PTR, 64'd0);
		send_item(iaf_pkg::MODE_PTR, 64'd1);
		send_item(iaf_pkg::MODE_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(iaf_pkg::MODE_PTR, 64'h8000_0000_0000_0000);
		send_item(iaf_pkg::MODE_PTR, 64'h0000_0001_0000_0000);
	endtask

	// codes past the pointer mode give no characters
	task automatic test_undefined_modes();
		for (int k = 1; k <= 3; k++)
			send_item(3'(iaf_pkg::MODE_PTR) + 3'(k), {$urandom, $urandom});
	endtask

	task automatic test_random_mix();
		int defined_sent;
		logic [2:0] act;
		defined_sent = 0;
		while (defined_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 5)
				act = 3'($urandom_range(5, 7));
			else
				act = 3'($urandom_range(0, 4));
			send_item(act, rand_value());
			if (act <= 3'(iaf_pkg::MODE_PTR))
				defined_sent++;
			// a long run back to back in the middle
			maybe_idle(defined_sent < 120 || defined_sent > 220);
		end
	endtask

	initial begin
		int drain;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		foreach (mode_count[m])
			mode_count[m] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_signed_decimal();
		test_unsigned_decimal();
		test_hex_cases();
		idle_gap(3);
		test_pointer();
		test_undefined_modes();
		test_random_mix();

		// let the last characters drain out
		start <= 1'b0;
		drain = 0;
		while (expected_chars.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0)
			note_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));

		$display("covered items: %0d signed dec, %0d unsigned dec, %0d hex lower,",
			mode_count[0], mode_count[1], mode_count[2]);
		$display("  %0d hex upper, %0d pointer, %0d undefined mode; %0d chars checked",
			mode_count[3], mode_count[4], mode_count[5] + mode_count[6] + mode_count[7],
			chars_checked);
		$display("  %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
